// ----- hw/rtl/clce_pkg.sv -----
// Shared types, constants and helper functions for the C literal character escaper.
`timescale 1ns / 1ps
`default_nettype none

package clce_pkg;

    localparam int unsigned CharWidth  = 8;
    localparam int unsigned MaxChars   = 6;
    localparam int unsigned LenWidth   = $clog2(MaxChars + 1);
    localparam int unsigned QueueDepth = 4;
    localparam int unsigned QPtrWidth  = $clog2(QueueDepth);
    localparam int unsigned QCntWidth  = $clog2(QueueDepth + 1);
    localparam int unsigned CfgIdxWidth = 2;

    localparam logic [CharWidth-1:0] ChBackslash = 8'd92;
    localparam logic [CharWidth-1:0] ChSQuote    = 8'd39;
    localparam logic [CharWidth-1:0] ChDQuote    = 8'd34;
    localparam logic [CharWidth-1:0] ChSpace     = 8'd32;
    localparam logic [CharWidth-1:0] ChTilde     = 8'd126;
    localparam logic [CharWidth-1:0] ChLowerX    = 8'd120;
    localparam logic [CharWidth-1:0] ChDigit0    = 8'd48;
    localparam logic [CharWidth-1:0] ChUpperA    = 8'd65;

    typedef enum logic [CfgIdxWidth-1:0] {
        CFG_WITH_QUOTES = 2'd0,
        CFG_QUOTE_CHAR  = 2'd1,
        CFG_STRING_MODE = 2'd2,
        CFG_UNUSED      = 2'd3
    } cfg_index_t;

    // One classified item: the full spelling and its length (1..6).
    typedef struct packed {
        logic [LenWidth-1:0]                len;
        logic [MaxChars-1:0][CharWidth-1:0] chars;
    } esc_cmd_t;

    typedef struct packed {
        logic                 with_quotes;
        logic [CharWidth-1:0] quote_char;
        logic                 string_mode;
    } esc_cfg_t;

    // Fixed escape letter, or zero when the byte has none.
    function automatic logic [CharWidth-1:0] fixed_escape(input logic [CharWidth-1:0] b);
        logic [CharWidth-1:0] e;
        unique case (b)
            8'd92:   e = ChBackslash;
            8'd13:   e = 8'd114; // r
            8'd10:   e = 8'd110; // n
            8'd12:   e = 8'd102; // f
            8'd11:   e = 8'd118; // v
            8'd7:    e = 8'd97;  // a
            8'd8:    e = 8'd98;  // b
            8'd9:    e = 8'd116; // t
            default: e = '0;
        endcase
        return e;
    endfunction

    function automatic logic [CharWidth-1:0] hex_digit(input logic [3:0] n);
        logic [CharWidth-1:0] d;
        if (n < 4'd10)
            d = ChDigit0 + {4'b0, n};
        else
            d = ChUpperA + {4'b0, n} - 8'd10;
        return d;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/clce_front.sv -----
// Front end: configuration registers, input acceptance and classification into a spelling.
`timescale 1ns / 1ps
`default_nettype none

module clce_front (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [clce_pkg::CfgIdxWidth-1:0] cfg_index,
    input  wire logic [clce_pkg::CharWidth-1:0] cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [clce_pkg::CharWidth-1:0] char_in,
    input  wire logic                           string_start,
    input  wire logic                           string_end,
    output logic                                push,
    output clce_pkg::esc_cmd_t                  push_cmd,
    input  wire logic                           q_full
);
    import clce_pkg::*;

    esc_cfg_t cfg_reg;
    logic     fr_valid_reg;
    esc_cmd_t fr_cmd_reg;
    esc_cmd_t cmd_next;

    logic [CharWidth-1:0]       esc_letter;
    logic [CharWidth-1:0]       qchar;
    logic [3:0][CharWidth-1:0]  bare;
    logic [LenWidth-1:0]        blen;
    logic                       lead;
    logic                       trail;
    logic [CharWidth-1:0]       wrap_char;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cfg_reg.with_quotes <= 1'b0;
            cfg_reg.quote_char  <= ChSQuote;
            cfg_reg.string_mode <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_WITH_QUOTES: cfg_reg.with_quotes <= cfg_data[0];
                CFG_QUOTE_CHAR:  cfg_reg.quote_char  <= cfg_data;
                CFG_STRING_MODE: cfg_reg.string_mode <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Bare spelling of the byte
    always_comb begin
        esc_letter = fixed_escape(char_in);
        qchar      = cfg_reg.string_mode ? ChDQuote : cfg_reg.quote_char;
        bare       = '0;
        if (esc_letter != '0) begin
            bare[0] = ChBackslash;
            bare[1] = esc_letter;
            blen    = LenWidth'(2);
        end else if (char_in == qchar) begin
            bare[0] = ChBackslash;
            bare[1] = char_in;
            blen    = LenWidth'(2);
        end else if (char_in >= ChSpace && char_in <= ChTilde) begin
            bare[0] = char_in;
            blen    = LenWidth'(1);
        end else begin
            bare[0] = ChBackslash;
            bare[1] = ChLowerX;
            bare[2] = hex_digit(char_in[7:4]);
            bare[3] = hex_digit(char_in[3:0]);
            blen    = LenWidth'(4);
        end
    end

    // Wrap with quotes
    always_comb begin
        logic [LenWidth-1:0] k;
        lead      = cfg_reg.with_quotes && (cfg_reg.string_mode ? string_start : 1'b1);
        trail     = cfg_reg.with_quotes && (cfg_reg.string_mode ? string_end : 1'b1);
        wrap_char = cfg_reg.string_mode ? ChDQuote : ChSQuote;
        cmd_next.len = {{(LenWidth-1){1'b0}}, lead} + blen + {{(LenWidth-1){1'b0}}, trail};
        for (int i = 0; i < MaxChars; i++) begin
            // position within the bare spelling; wraps high for the leading quote slot
            k = LenWidth'(i) - {{(LenWidth-1){1'b0}}, lead};
            if (lead && i == 0)
                cmd_next.chars[i] = wrap_char;
            else if (k < blen)
                cmd_next.chars[i] = bare[k[1:0]];
            else if (trail && k == blen)
                cmd_next.chars[i] = wrap_char;
            else
                cmd_next.chars[i] = '0;
        end
    end

    assign push     = fr_valid_reg && !q_full;
    assign push_cmd = fr_cmd_reg;
    assign in_ready = !fr_valid_reg || !q_full;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            fr_valid_reg <= 1'b0;
        else if (in_ready)
            fr_valid_reg <= in_valid;
    end

    always_ff @(posedge clk) begin
        if (in_ready && in_valid)
            fr_cmd_reg <= cmd_next;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/clce_queue.sv -----
// Short queue of classified items between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module clce_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire clce_pkg::esc_cmd_t push_cmd,
    output logic                    full,
    input  wire logic               pop,
    output logic                    head_valid,
    output clce_pkg::esc_cmd_t      head_cmd
);
    import clce_pkg::*;

    esc_cmd_t               mem_reg [QueueDepth];
    logic [QPtrWidth-1:0]   wr_ptr_reg;
    logic [QPtrWidth-1:0]   rd_ptr_reg;
    logic [QCntWidth-1:0]   count_reg;
    logic                   do_push;
    logic                   do_pop;

    assign full       = (count_reg == QCntWidth'(QueueDepth));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk) begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/clce_back.sv -----
// Back end: walks each queued spelling and emits one character per transaction.
`timescale 1ns / 1ps
`default_nettype none

module clce_back (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           head_valid,
    input  wire clce_pkg::esc_cmd_t             head_cmd,
    output logic                                pop,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [clce_pkg::CharWidth-1:0]      out_char,
    output logic                                run_last
);
    import clce_pkg::*;

    logic [LenWidth-1:0]  idx_reg;
    logic [LenWidth-1:0]  idx_next;
    logic                 out_valid_reg;
    logic [CharWidth-1:0] out_char_reg;
    logic                 run_last_reg;
    logic                 load;
    logic                 at_last;

    assign load    = head_valid && (!out_valid_reg || out_ready);
    assign at_last = (idx_reg == head_cmd.len - 1'b1);
    assign pop     = load && at_last;

    always_comb begin
        idx_next = idx_reg;
        if (load)
            idx_next = at_last ? '0 : idx_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            idx_reg <= idx_next;
            if (load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (load) begin
            out_char_reg <= head_cmd.chars[idx_reg];
            run_last_reg <= at_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign run_last  = run_last_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/c_literal_char_escaper_top.sv -----
// Top level of the C literal character escaper.
// An item passes through the front register, the queue and the back end's output register.
// One output character per cycle while out_ready is high and an item is queued; the back end
// walks an item's 1 to 6 characters; input is accepted every cycle while the queue is not full.
// A 4-entry queue decouples classification from emission.
// Reset (rst_n low, async): queue empty, no output; with_quotes 0, quote_char 39, string_mode 0.
`timescale 1ns / 1ps
`default_nettype none

module c_literal_char_escaper_top (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [clce_pkg::CfgIdxWidth-1:0] cfg_index,
    input  wire logic [clce_pkg::CharWidth-1:0]   cfg_data,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [clce_pkg::CharWidth-1:0]   char_in,
    input  wire logic                             string_start,
    input  wire logic                             string_end,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [clce_pkg::CharWidth-1:0]        out_char,
    output logic                                  run_last
);
    import clce_pkg::*;

    logic     push;
    esc_cmd_t push_cmd;
    logic     q_full;
    logic     pop;
    logic     head_valid;
    esc_cmd_t head_cmd;

    clce_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .char_in      (char_in),
        .string_start (string_start),
        .string_end   (string_end),
        .push         (push),
        .push_cmd     (push_cmd),
        .q_full       (q_full)
    );

    clce_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    clce_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_char   (out_char),
        .run_last   (run_last)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/clce_checker.sv -----
// Port-level checker for the C literal character escaper, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module clce_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             cfg_valid,
    input wire logic                             cfg_ready,
    input wire logic                             out_valid,
    input wire logic                             out_ready,
    input wire logic [clce_pkg::CharWidth-1:0]   out_char,
    input wire logic                             run_last
);

    // Stalled output transaction holds its payload.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_char) && $stable(run_last))
        else $error("output payload changed while stalled");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output valid dropped while stalled");

    // Characters of one item come out back to back.
    a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !run_last |=> out_valid)
        else $error("gap inside one item's spelling");

    a_cfg_always_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind c_literal_char_escaper_top clce_checker u_clce_checker (.*);

`default_nettype wire

// ----- test/testbench.sv -----
// Self-checking testbench for the C literal character escaper.
`timescale 1ns / 1ps

module testbench;
    import clce_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS = 25;
    localparam int NUM_PHASES = 10;

    typedef struct packed {
        logic [CharWidth-1:0] ch;
        logic                 last;
    } out_beat_t;

    // Directed stimulus: config to run under, the item, and an optional typed spelling
    // (typed_len 0 means the predictor supplies the expectation).
    typedef struct packed {
        logic                 wq;
        logic [CharWidth-1:0] qc;
        logic                 sm;
        logic [CharWidth-1:0] ch;
        logic                 st;
        logic                 en;
        logic [2:0]           typed_len;
        logic [47:0]          typed_text;
    } dir_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CfgIdxWidth-1:0] cfg_index = '0;
    logic [CharWidth-1:0]   cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [CharWidth-1:0]   char_in = '0;
    logic                   string_start = 1'b0;
    logic                   string_end = 1'b0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [CharWidth-1:0]   out_char;
    logic                   run_last;

    // Predictor copy of the registers
    logic                 cfg_wq = 1'b0;
    logic [CharWidth-1:0] cfg_qc = 8'd39;
    logic                 cfg_sm = 1'b0;

    out_beat_t expected_beats[$];
    int        mismatches = 0;
    int        idle_cycles = 0;
    logic      burst = 1'b0;

    dir_row_t directed_rows [25] = '{
        '{1'b0, 8'd39, 1'b0, 8'd0,   1'b0, 1'b0, 3'd4, "\\x00"},
        '{1'b0, 8'd39, 1'b0, 8'd255, 1'b1, 1'b0, 3'd4, "\\xFF"},
        '{1'b0, 8'd39, 1'b0, 8'd92,  1'b0, 1'b0, 3'd2, "\\\\"},
        '{1'b0, 8'd39, 1'b0, 8'd39,  1'b0, 1'b0, 3'd2, "\\'"},
        '{1'b0, 8'd39, 1'b0, 8'd34,  1'b0, 1'b0, 3'd1, "\""},
        '{1'b0, 8'd39, 1'b0, 8'd32,  1'b0, 1'b0, 3'd1, " "},
        '{1'b0, 8'd39, 1'b0, 8'd126, 1'b0, 1'b0, 3'd1, "~"},
        '{1'b0, 8'd39, 1'b0, 8'd127, 1'b0, 1'b0, 3'd4, "\\x7F"},
        '{1'b0, 8'd39, 1'b0, 8'd31,  1'b0, 1'b0, 3'd4, "\\x1F"},
        '{1'b0, 8'd39, 1'b0, 8'd13,  1'b0, 1'b0, 3'd2, "\\r"},
        '{1'b0, 8'd39, 1'b0, 8'd10,  1'b0, 1'b0, 3'd2, "\\n"},
        '{1'b0, 8'd39, 1'b0, 8'd12,  1'b0, 1'b0, 3'd2, "\\f"},
        '{1'b0, 8'd39, 1'b0, 8'd11,  1'b0, 1'b0, 3'd2, "\\v"},
        '{1'b0, 8'd39, 1'b0, 8'd7,   1'b0, 1'b0, 3'd2, "\\a"},
        '{1'b0, 8'd39, 1'b0, 8'd8,   1'b0, 1'b0, 3'd2, "\\b"},
        '{1'b0, 8'd39, 1'b0, 8'd9,   1'b0, 1'b0, 3'd2, "\\t"},
        // character mode ignores the string markers
        '{1'b1, 8'd39, 1'b0, 8'd65,  1'b1, 1'b1, 3'd3, "'A'"},
        '{1'b1, 8'd39, 1'b0, 8'd200, 1'b0, 1'b1, 3'd6, "'\\xC8'"},
        // fixed escape wins over a matching quote char
        '{1'b1, 8'd10, 1'b0, 8'd10,  1'b0, 1'b0, 3'd4, "'\\n'"},
        // quote char match, unprintable or printable: backslash plus the raw byte
        '{1'b0, 8'd200, 1'b0, 8'd200, 1'b0, 1'b0, 3'd0, '0},
        '{1'b0, 8'd65, 1'b0, 8'd65,  1'b0, 1'b0, 3'd2, "\\A"},
        // string mode: quote_char is ignored, double quote is escaped
        '{1'b1, 8'd65, 1'b1, 8'd65,  1'b0, 1'b0, 3'd1, "A"},
        '{1'b1, 8'd39, 1'b1, 8'd34,  1'b1, 1'b0, 3'd3, "\"\\\""},
        '{1'b1, 8'd39, 1'b1, 8'd10,  1'b0, 1'b1, 3'd3, "\\n\""},
        '{1'b1, 8'd39, 1'b1, 8'd0,   1'b1, 1'b1, 3'd6, "\"\\x00\""}
    };

    c_literal_char_escaper_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .char_in      (char_in),
        .string_start (string_start),
        .string_end   (string_end),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_char     (out_char),
        .run_last     (run_last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [CharWidth-1:0] escape_letter(input logic [CharWidth-1:0] b);
        case (b)
            8'd92:   return ChBackslash;
            8'd13:   return "r";
            8'd10:   return "n";
            8'd12:   return "f";
            8'd11:   return "v";
            8'd7:    return "a";
            8'd8:    return "b";
            8'd9:    return "t";
            default: return 8'd0;
        endcase
    endfunction

    function automatic logic [CharWidth-1:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
            return "0" + {4'b0, n};
        return "A" + {4'b0, n} - 8'd10;
    endfunction

    // Spell one byte under the current register copy and queue the characters.
    function automatic void record_escape(input logic [CharWidth-1:0] b, input logic st,
                                          input logic en);
        logic [CharWidth-1:0] seq[$];
        logic [CharWidth-1:0] q;
        logic [CharWidth-1:0] wrap;
        logic [CharWidth-1:0] letter;
        out_beat_t beat;
        q = cfg_sm ? ChDQuote : cfg_qc;
        wrap = cfg_sm ? ChDQuote : ChSQuote;
        letter = escape_letter(b);
        if (cfg_wq && (!cfg_sm || st))
            seq.push_back(wrap);
        if (letter != 8'd0)
        begin
            seq.push_back(ChBackslash);
            seq.push_back(letter);
        end
        else if (b == q)
        begin
            seq.push_back(ChBackslash);
            seq.push_back(b);
        end
        else if (b >= ChSpace && b <= ChTilde)
            seq.push_back(b);
        else
        begin
            seq.push_back(ChBackslash);
            seq.push_back(ChLowerX);
            seq.push_back(hex_char(b[7:4]));
            seq.push_back(hex_char(b[3:0]));
        end
        if (cfg_wq && (!cfg_sm || en))
            seq.push_back(wrap);
        foreach (seq[i])
        begin
            beat.ch = seq[i];
            beat.last = (i == seq.size() - 1);
            expected_beats.push_back(beat);
        end
    endfunction

    function automatic logic [CharWidth-1:0] pick_escape_byte();
        case ($urandom_range(7))
            0:       return 8'd92;
            1:       return 8'd13;
            2:       return 8'd10;
            3:       return 8'd12;
            4:       return 8'd11;
            5:       return 8'd7;
            6:       return 8'd8;
            default: return 8'd9;
        endcase
    endfunction

    function automatic logic [CharWidth-1:0] pick_byte();
        case ($urandom_range(9))
            0, 1, 2, 3: return 8'($urandom_range(255));
            4, 5:       return 8'($urandom_range(126, 32));
            6:          return pick_escape_byte();
            7:          return cfg_qc;
            8:          return $urandom_range(1) ? ChDQuote : ChSQuote;
            default:
            begin
                case ($urandom_range(5))
                    0:       return 8'd0;
                    1:       return 8'd31;
                    2:       return 8'd32;
                    3:       return 8'd126;
                    4:       return 8'd127;
                    default: return 8'd255;
                endcase
            end
        endcase
    endfunction

    function automatic logic [CharWidth-1:0] pick_quote();
        case ($urandom_range(4))
            0:       return 8'($urandom_range(255));
            1:       return pick_escape_byte();
            2:       return 8'($urandom_range(126, 32));
            3:       return $urandom_range(1) ? ChDQuote : ChSQuote;
            default: return 8'($urandom_range(255, 127));
        endcase
    endfunction

    // Offer one item, wait for the transaction, then queue its expected characters.
    task automatic send_item(input logic [CharWidth-1:0] ch, input logic st, input logic en,
                             input logic [2:0] typed_len, input logic [47:0] typed_text);
        int gap;
        out_beat_t beat;
        gap = 0;
        while (!burst && $urandom_range(99) < 15)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        char_in <= ch;
        string_start <= st;
        string_end <= en;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (typed_len != 3'd0)
        begin
            for (int i = 0; i < typed_len; i++)
            begin
                beat.ch = typed_text[8 * (typed_len - 1 - i) +: 8];
                beat.last = (i == typed_len - 1);
                expected_beats.push_back(beat);
            end
        end
        else
            record_escape(ch, st, en);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CharWidth-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_WITH_QUOTES: cfg_wq = data[0];
            CFG_QUOTE_CHAR:  cfg_qc = data;
            CFG_STRING_MODE: cfg_sm = data[0];
            default:         ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Stop offering input and let every expected character come out.
    task automatic settle();
        in_valid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    always @(posedge clk)
        out_ready <= burst ? 1'b1 : ($urandom_range(99) >= 15);

    always @(posedge clk)
    begin
        out_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_beats.size() == 0)
            begin
                $display("%0t: unexpected transaction out_char=%0d run_last=%0d",
                         $time, out_char, run_last);
                mismatches++;
            end
            else
            begin
                want = expected_beats.pop_front();
                if (out_char !== want.ch)
                begin
                    $display("%0t: out_char expected %0d actual %0d", $time, want.ch, out_char);
                    mismatches++;
                end
                if (run_last !== want.last)
                begin
                    $display("%0t: run_last expected %0d actual %0d",
                             $time, want.last, run_last);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial
    begin
        dir_row_t row;
        int sent;
        int len;
        logic broken;
        logic st;
        logic en;
        logic [CharWidth-1:0] qc;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            row = directed_rows[r];
            if (row.wq != cfg_wq || row.qc != cfg_qc || row.sm != cfg_sm)
            begin
                settle();
                if (row.wq != cfg_wq)
                    write_reg(CFG_WITH_QUOTES, {7'b0, row.wq});
                if (row.qc != cfg_qc)
                    write_reg(CFG_QUOTE_CHAR, row.qc);
                if (row.sm != cfg_sm)
                    write_reg(CFG_STRING_MODE, {7'b0, row.sm});
            end
            send_item(row.ch, row.st, row.en, row.typed_len, row.typed_text);
        end

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            settle();
            burst = (phase == 6 || phase == 7);
            case (phase)
                0:       qc = 8'd0;
                1, 2:    qc = 8'd255;
                default: qc = pick_quote();
            endcase
            write_reg(CFG_WITH_QUOTES, (phase == 0) ? 8'd0 : (phase < 3) ? 8'd1 :
                      8'($urandom_range(255)));
            write_reg(CFG_QUOTE_CHAR, qc);
            write_reg(CFG_STRING_MODE, (phase == 1) ? 8'd1 : (phase < 3) ? 8'd0 :
                      8'($urandom_range(255)));
            // the spare index must leave every register alone
            write_reg(CFG_UNUSED, 8'($urandom_range(255)));

            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                if (cfg_sm)
                begin
                    // mostly well-formed strings, some with stray or missing markers
                    len = $urandom_range(6, 1);
                    broken = ($urandom_range(99) < 20);
                    for (int k = 0; k < len; k++)
                    begin
                        st = broken ? 1'($urandom_range(1)) : (k == 0);
                        en = broken ? 1'($urandom_range(1)) : (k == len - 1);
                        send_item(pick_byte(), st, en, 3'd0, '0);
                        sent++;
                    end
                end
                else
                begin
                    send_item(pick_byte(), 1'($urandom_range(1)), 1'($urandom_range(1)),
                              3'd0, '0);
                    sent++;
                end
            end
        end
        burst = 1'b0;
        settle();

        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
